>>> hdl/swm_pkg.sv
// Package for the sliding window median filter.
// Holds the default window length, the age width and the link record passed between cells.
// No dependencies.
package swm_pkg;

    localparam int WINDOW_DEF = 15;
    localparam int WINDOW_MAX = 63;
    localparam int DATA_W     = 32;
    localparam int AGE_W      = $clog2(WINDOW_MAX + 1);

    typedef logic [AGE_W-1:0] t_age;

    // what a cell shows its neighbors
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_age                     age;
        logic                     gt;        // value > incoming sample
        logic                     del_upto;  // oldest entry sits here or further left
    } t_link;

endpackage

>>> hdl/swm_cell.sv
// One cell of the sorted chain: a value and its age.
// Takes its next content from itself or a neighbor, or takes the new sample.
// Depends on swm_pkg.
module swm_cell #(
    parameter int WINDOW   = swm_pkg::WINDOW_DEF,
    parameter int INIT_AGE = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic signed [swm_pkg::DATA_W-1:0]    i_sample,
    input  swm_pkg::t_link                       i_left,
    input  swm_pkg::t_link                       i_right,
    output swm_pkg::t_link                       o_link
);
    import swm_pkg::*;

    logic signed [DATA_W-1:0] r_value, n_value;
    t_age                     r_age, n_age;

    logic                     w_del_self;
    logic                     w_del_upto;
    logic                     w_gt;
    logic signed [DATA_W-1:0] w_c_val, w_p_val;
    t_age                     w_c_age, w_p_age;
    logic                     w_c_gt, w_p_gt;

    assign w_del_self = (r_age == AGE_W'(WINDOW - 1));
    assign w_del_upto = i_left.del_upto | w_del_self;
    assign w_gt       = (r_value > i_sample);

    assign o_link.value    = r_value;
    assign o_link.age      = r_age;
    assign o_link.gt       = w_gt;
    assign o_link.del_upto = w_del_upto;

    // content after removing the oldest entry: this slot and the one to the left
    assign w_c_val = w_del_upto ? i_right.value : r_value;
    assign w_c_age = w_del_upto ? i_right.age   : r_age;
    assign w_c_gt  = w_del_upto ? i_right.gt    : w_gt;
    assign w_p_val = i_left.del_upto ? r_value : i_left.value;
    assign w_p_age = i_left.del_upto ? r_age   : i_left.age;
    assign w_p_gt  = i_left.del_upto ? w_gt    : i_left.gt;

    always_comb begin
        if (!w_c_gt) begin
            n_value = w_c_val;
            n_age   = w_c_age + t_age'(1);
        end else if (!w_p_gt) begin
            n_value = i_sample;
            n_age   = '0;
        end else begin
            n_value = w_p_val;
            n_age   = w_p_age + t_age'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_age   <= AGE_W'(INIT_AGE);
        end else if (i_load) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

endmodule

>>> hdl/sliding_window_median.sv
// Sliding window median: a chain of WINDOW sorted cells, each with a value and an age.
// Median valid the cycle after input; one transaction per cycle unless output stalls.
// Each transaction drops the oldest cell and inserts the sample in one step of the chain.
// The result is held in the middle cell until taken; a new sample enters as it is taken.
// Synchronous active-low reset: window cleared to zero, no result pending.
module sliding_window_median #(
    parameter int WINDOW = swm_pkg::WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic signed [swm_pkg::DATA_W-1:0] i_s_axis_tdata,   // [31:0] sample
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic signed [swm_pkg::DATA_W-1:0] o_m_axis_tdata    // [31:0] median
);
    import swm_pkg::*;

    logic  r_valid;
    logic  w_load;
    t_link w_link [WINDOW];
    t_link w_edge_lo, w_edge_hi;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign w_load          = i_s_axis_tvalid && o_s_axis_tready;

    // sentinels: minus infinity on the left, plus infinity on the right
    assign w_edge_lo = '{value: '0, age: '0, gt: 1'b0, del_upto: 1'b0};
    assign w_edge_hi = '{value: '0, age: '0, gt: 1'b1, del_upto: 1'b0};

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        swm_cell #(
            .WINDOW   (WINDOW),
            .INIT_AGE (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (w_load),
            .i_sample (i_s_axis_tdata),
            .i_left   ((g == 0) ? w_edge_lo : w_link[(g == 0) ? 0 : g - 1]),
            .i_right  ((g == WINDOW - 1) ? w_edge_hi
                                         : w_link[(g == WINDOW - 1) ? g : g + 1]),
            .o_link   (w_link[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = w_link[WINDOW/2].value;

endmodule
